// ----- src/acal_pkg.sv -----
// ----------------------------------------------------------------------------
// acal_pkg
// Operation codes and shared types of the 8-bit accumulator ALU.
// ----------------------------------------------------------------------------
package acal_pkg;

    typedef enum logic [3:0] {
        KIND_READ = 4'd0,
        KIND_LOAD = 4'd1,
        KIND_ADD  = 4'd2,
        KIND_ADC  = 4'd3,
        KIND_SUB  = 4'd4,
        KIND_SBB  = 4'd5,
        KIND_AND  = 4'd6,
        KIND_XOR  = 4'd7,
        KIND_OR   = 4'd8,
        KIND_CMP  = 4'd9,
        KIND_RLC  = 4'd10,
        KIND_RRC  = 4'd11,
        KIND_RAL  = 4'd12
    } kind_t;

    typedef struct packed {
        logic carry;
        logic sign;
        logic zero;
    } flags_t;

    typedef struct packed {
        logic [7:0] acc;
        flags_t     flags;
    } alu_state_t;

endpackage

// ----- src/acal_exec.sv -----
// ----------------------------------------------------------------------------
// acal_exec
// Single-pass operation logic: next accumulator and flags from the current
// state and one operation word.
// ----------------------------------------------------------------------------
module acal_exec (
    input  acal_pkg::alu_state_t state_cur,
    input  logic [3:0]           kind,
    input  logic [7:0]           data,
    input  logic                 rar,
    output acal_pkg::alu_state_t state_new
);

    logic [7:0] a;
    logic       cin;
    logic [8:0] sum9;
    logic [8:0] subtrahend9;
    logic [9:0] diff10;
    logic [7:0] logic_res;

    assign a   = state_cur.acc;
    assign cin = state_cur.flags.carry;

    always_comb
    begin
        sum9        = {1'b0, a} + {1'b0, data}
                      + {8'd0, (acal_pkg::kind_t'(kind) == acal_pkg::KIND_ADC) & cin};
        subtrahend9 = {1'b0, data}
                      + {8'd0, (acal_pkg::kind_t'(kind) == acal_pkg::KIND_SBB) & cin};
        diff10      = {2'b00, a} - {1'b0, subtrahend9};

        case (acal_pkg::kind_t'(kind))
            acal_pkg::KIND_AND: logic_res = a & data;
            acal_pkg::KIND_XOR: logic_res = a ^ data;
            default:            logic_res = a | data;
        endcase

        state_new = state_cur;
        if (rar)
        begin
            state_new.acc         = {cin, a[7:1]};
            state_new.flags.carry = a[0];
        end
        else
        begin
            case (acal_pkg::kind_t'(kind))
                acal_pkg::KIND_LOAD:
                begin
                    state_new.acc = data;
                end
                acal_pkg::KIND_ADD, acal_pkg::KIND_ADC:
                begin
                    state_new.acc         = sum9[7:0];
                    state_new.flags.carry = sum9[8];
                    state_new.flags.sign  = sum9[7];
                    state_new.flags.zero  = (sum9[7:0] == 8'd0);
                end
                acal_pkg::KIND_SUB, acal_pkg::KIND_SBB, acal_pkg::KIND_CMP:
                begin
                    if (acal_pkg::kind_t'(kind) != acal_pkg::KIND_CMP)
                    begin
                        state_new.acc = diff10[7:0];
                    end
                    state_new.flags.carry = diff10[9];
                    state_new.flags.sign  = diff10[7];
                    state_new.flags.zero  = (diff10[7:0] == 8'd0);
                end
                acal_pkg::KIND_AND, acal_pkg::KIND_XOR, acal_pkg::KIND_OR:
                begin
                    state_new.acc         = logic_res;
                    state_new.flags.carry = 1'b0;
                    state_new.flags.sign  = logic_res[7];
                    state_new.flags.zero  = (logic_res == 8'd0);
                end
                acal_pkg::KIND_RLC:
                begin
                    state_new.acc         = {a[6:0], a[7]};
                    state_new.flags.carry = a[7];
                end
                acal_pkg::KIND_RRC:
                begin
                    state_new.acc         = {a[0], a[7:1]};
                    state_new.flags.carry = a[0];
                end
                acal_pkg::KIND_RAL:
                begin
                    state_new.acc         = {a[6:0], cin};
                    state_new.flags.carry = a[7];
                end
                default:
                begin
                    state_new = state_cur;
                end
            endcase
        end
    end

endmodule

// ----- src/accumulator_alu_8bit.sv -----
// ----------------------------------------------------------------------------
// accumulator_alu_8bit
// 8-bit accumulator ALU with carry, sign and zero flags.
// Each word passes the input register, then the result register.
// Throughput: one word per cycle while out_ready does not stall the output.
// The input register takes a new word while a finished result waits.
// Reset clears the accumulator and flags and empties both registers.
// ----------------------------------------------------------------------------
module accumulator_alu_8bit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] kind,
    input  logic [7:0] data_in,
    input  logic       rotate_right_through,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] acc_out,
    output logic       carry_out,
    output logic       sign_out,
    output logic       zero_out
);

    logic                 in_valid_reg;
    logic [3:0]           kind_reg;
    logic [7:0]           data_reg;
    logic                 rar_reg;
    logic                 out_valid_reg;
    acal_pkg::alu_state_t result_reg;
    acal_pkg::alu_state_t state_reg;
    acal_pkg::alu_state_t state_next;
    logic                 advance;

    assign advance  = in_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~in_valid_reg | advance;

    acal_exec u_exec (
        .state_cur (state_reg),
        .kind      (kind_reg),
        .data      (data_reg),
        .rar       (rar_reg),
        .state_new (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kind;
            data_reg <= data_in;
            rar_reg  <= rotate_right_through;
        end
        if (advance)
        begin
            result_reg <= state_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign acc_out   = result_reg.acc;
    assign carry_out = result_reg.flags.carry;
    assign sign_out  = result_reg.flags.sign;
    assign zero_out  = result_reg.flags.zero;

endmodule

// ----- src/acal_checker.sv -----
// ----------------------------------------------------------------------------
// acal_checker
// Port-level checks of the accumulator ALU, bound to the top level.
// ----------------------------------------------------------------------------
module acal_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] acc_out,
    input logic       carry_out,
    input logic       sign_out,
    input logic       zero_out
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(acc_out)
            && $stable(carry_out) && $stable(sign_out) && $stable(zero_out))
        else $error("result word changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with result register empty");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |-> ##2 out_valid)
        else $error("result missing two cycles after accept");

endmodule

bind accumulator_alu_8bit acal_checker u_acal_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .acc_out   (acc_out),
    .carry_out (carry_out),
    .sign_out  (sign_out),
    .zero_out  (zero_out)
);
